// ===== sv/crpi_pkg.sv =====
// Climb-rate PI controller package: item and config types, widths, register
// indexes, reset values and the op word of the shared multiply-accumulate.
// No dependencies.
package crpi_pkg;

  localparam int TICK_W     = 16;
  localparam int ALT_W      = 25;
  localparam int Q15_W      = 16;
  localparam int GAIN_W     = 24;
  localparam int PERIOD_W   = 20;
  localparam int LIMIT_W    = 15;
  localparam int TIMER_W    = 22;
  localparam int RCHG_W     = 26;
  localparam int MAC_A_W    = 26;
  localparam int MAC_B_W    = 24;
  localparam int PROD_W     = MAC_A_W + MAC_B_W;
  localparam int ACC_W      = 60;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam int HALF_Q15    = 16384;
  localparam int FILT_SHIFT  = 3;
  localparam int RATE_SHIFT  = 2;
  localparam int DRV_SHIFT   = 9;
  localparam int SETP_SHIFT  = 15;

  localparam logic [PERIOD_W-1:0] CTRL_PERIOD_RST  = PERIOD_W'(18600);
  localparam logic [PERIOD_W-1:0] SMPL_PERIOD_RST  = PERIOD_W'(168000);
  localparam logic [PERIOD_W-1:0] SMPL_DELAY_RST   = PERIOD_W'(84000);
  localparam logic [LIMIT_W-1:0]  INTEG_LIMIT_RST  = LIMIT_W'(16384);

  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STICK_SCALE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CONTROL_PERIOD = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PERIOD  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_DELAY   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_LIMIT    = 3'd7;

  typedef struct packed {
    logic [TICK_W-1:0] tick_us;
    logic [ALT_W-1:0]  altitude_counts;
    logic [Q15_W-1:0]  stick;
    logic [Q15_W-1:0]  elevator_in;
  } tick_item_t;

  typedef struct packed {
    logic [Q15_W-1:0] elevator_out;
    logic [Q15_W-1:0] drive;
    logic             updated;
  } result_item_t;

  typedef struct packed {
    logic [GAIN_W-1:0]   prop_gain;
    logic [GAIN_W-1:0]   deriv_gain;
    logic [GAIN_W-1:0]   integ_gain;
    logic [GAIN_W-1:0]   stick_scale;
    logic [PERIOD_W-1:0] control_period;
    logic [PERIOD_W-1:0] sample_period;
    logic [PERIOD_W-1:0] sample_delay;
    logic [LIMIT_W-1:0]  integ_limit;
  } cfg_t;

  // one issue to the shared multiply-accumulate
  typedef struct packed {
    logic               issue;
    logic               clear;
    logic               sub;
    logic               shift;
    logic [MAC_A_W-1:0] a;
    logic [MAC_B_W-1:0] b;
  } mac_op_t;

endpackage

// ===== sv/crpi_cfg.sv =====
// Climb-rate PI controller configuration registers.
// Depends on crpi_pkg.
module crpi_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [crpi_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [crpi_pkg::CFG_DATA_W-1:0] cfg_data,
  output crpi_pkg::cfg_t                   cfg
);
  import crpi_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.prop_gain      <= '0;
      cfg.deriv_gain     <= '0;
      cfg.integ_gain     <= '0;
      cfg.stick_scale    <= '0;
      cfg.control_period <= CTRL_PERIOD_RST;
      cfg.sample_period  <= SMPL_PERIOD_RST;
      cfg.sample_delay   <= SMPL_DELAY_RST;
      cfg.integ_limit    <= INTEG_LIMIT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_PROP_GAIN:      cfg.prop_gain      <= cfg_data[GAIN_W-1:0];
        REG_DERIV_GAIN:     cfg.deriv_gain     <= cfg_data[GAIN_W-1:0];
        REG_INTEG_GAIN:     cfg.integ_gain     <= cfg_data[GAIN_W-1:0];
        REG_STICK_SCALE:    cfg.stick_scale    <= cfg_data[GAIN_W-1:0];
        REG_CONTROL_PERIOD: cfg.control_period <= cfg_data[PERIOD_W-1:0];
        REG_SAMPLE_PERIOD:  cfg.sample_period  <= cfg_data[PERIOD_W-1:0];
        REG_SAMPLE_DELAY:   cfg.sample_delay   <= cfg_data[PERIOD_W-1:0];
        REG_INTEG_LIMIT:    cfg.integ_limit    <= cfg_data[LIMIT_W-1:0];
      endcase
    end
  end

endmodule

// ===== sv/crpi_mac.sv =====
// Climb-rate PI controller shared signed multiply-accumulate.
// Registered product, then accumulate (optional <<8, add or subtract, clear).
// Depends on crpi_pkg.
module crpi_mac (
  input  logic                               clk,
  input  logic                               rst,
  input  crpi_pkg::mac_op_t                  op,
  output logic signed [crpi_pkg::PROD_W-1:0] prod,
  output logic signed [crpi_pkg::ACC_W-1:0]  acc,
  output logic                               busy
);
  import crpi_pkg::*;

  logic p_valid;
  logic p_clear;
  logic p_sub;
  logic p_shift;
  logic signed [ACC_W-1:0] term;
  logic signed [ACC_W-1:0] base;
  logic signed [ACC_W-1:0] acc_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else begin
      p_valid <= op.issue;
    end
    prod    <= $signed(op.a) * $signed(op.b);
    p_clear <= op.clear;
    p_sub   <= op.sub;
    p_shift <= op.shift;
  end

  always_comb begin
    term = {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
    if (p_shift) begin
      term = term <<< 8;
    end
    base     = p_clear ? '0 : acc;
    acc_next = p_sub ? base - term : base + term;
  end

  always_ff @(posedge clk) begin
    if (p_valid) begin
      acc <= acc_next;
    end
  end

  assign busy = p_valid;

endmodule

// ===== sv/climb_rate_pi_controller.sv =====
// Climb-rate PI controller with anti-windup, top level: timers, altitude filter,
// sequencer over the shared multiply-accumulate, result register.
// Depends on crpi_pkg, crpi_cfg, crpi_mac.
// Each item runs filter and timer steps; on a control update a setpoint product,
// four products and the drive clamp, then, unless it clamped, two integrator
// products and the integrator update; the result step waits for a free result
// register. Accepts only when idle; a waiting result does not block accept.
// Reset (synchronous): loop state zero, config to defaults, no result pending.
module climb_rate_pi_controller (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             tick_valid,
  output logic                             tick_ready,
  input  crpi_pkg::tick_item_t             tick_item,
  output logic                             result_valid,
  input  logic                             result_ready,
  output crpi_pkg::result_item_t           result_item,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [crpi_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [crpi_pkg::CFG_DATA_W-1:0] cfg_data
);
  import crpi_pkg::*;

  localparam int DRV_W = ACC_W - DRV_SHIFT;
  localparam logic signed [DRV_W-1:0] DRV_MAX = DRV_W'(HALF_Q15);
  localparam logic signed [DRV_W-1:0] DRV_MIN = -DRV_MAX;
  localparam logic signed [TIMER_W-1:0] TIMER_MIN = {1'b1, {(TIMER_W-1){1'b0}}};
  localparam logic signed [ALT_W-1:0] ALT_MAX = {1'b0, {(ALT_W-1){1'b1}}};
  localparam logic signed [ALT_W-1:0] ALT_MIN = {1'b1, {(ALT_W-1){1'b0}}};
  localparam logic signed [Q15_W-1:0] Q15_MAX = {1'b0, {(Q15_W-1){1'b1}}};
  localparam logic signed [Q15_W-1:0] Q15_MIN = {1'b1, {(Q15_W-1){1'b0}}};
  localparam logic [MAC_B_W-1:0] INTEG_SCALE = MAC_B_W'(1 << DRV_SHIFT);

  typedef enum logic [15:0] {
    S_IDLE = 16'h0001,
    S_FILT = 16'h0002,
    S_TIME = 16'h0004,
    S_SETP = 16'h0008,
    S_SCAP = 16'h0010,
    S_P0   = 16'h0020,
    S_P1   = 16'h0040,
    S_P2   = 16'h0080,
    S_P3   = 16'h0100,
    S_ACCW = 16'h0200,
    S_DRV  = 16'h0400,
    S_I0   = 16'h0800,
    S_I1   = 16'h1000,
    S_IW   = 16'h2000,
    S_INTG = 16'h4000,
    S_FIN  = 16'h8000
  } state_t;

  state_t state;
  state_t state_next;

  cfg_t    cfg;
  mac_op_t mop;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;
  logic                     mac_busy;

  tick_item_t item;
  logic signed [TIMER_W-1:0] delay_timer;
  logic signed [TIMER_W-1:0] sample_timer;
  logic signed [TIMER_W-1:0] control_timer;
  logic signed [ALT_W-1:0]   alt_latched;
  logic signed [ALT_W-1:0]   alt_filtered;
  logic signed [ALT_W-1:0]   alt_previous;
  logic signed [ALT_W-1:0]   rate_filtered;
  logic signed [ALT_W-1:0]   rate_raw;
  logic signed [RCHG_W-1:0]  rate_change;
  logic signed [Q15_W-1:0]   integrator;
  logic signed [Q15_W-1:0]   last_drive;
  logic                      primed;
  logic                      updated;
  logic signed [ALT_W-1:0]   setp;

  crpi_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  crpi_mac u_mac (
    .clk  (clk),
    .rst  (rst),
    .op   (mop),
    .prod (prod),
    .acc  (acc),
    .busy (mac_busy)
  );

  assign tick_ready = (state == S_IDLE);

  // dead time and filter
  logic signed [TIMER_W:0]  tick_ext;
  logic signed [TIMER_W:0]  dt_dec;
  logic                     dt_run;
  logic signed [ALT_W:0]    flt_diff;
  logic signed [ALT_W-1:0]  rate_new;
  logic signed [ALT_W-1:0]  af_new;
  logic signed [RCHG_W-1:0] rc_new;
  logic signed [ALT_W:0]    raw_full;
  logic signed [ALT_W-1:0]  raw_sat;

  always_comb begin
    tick_ext = {{(TIMER_W+1-TICK_W){1'b0}}, item.tick_us};
    dt_dec   = {delay_timer[TIMER_W-1], delay_timer} - tick_ext;
    dt_run   = !delay_timer[TIMER_W-1] && (delay_timer != '0);
    flt_diff = $signed({alt_latched[ALT_W-1], alt_latched}
               - {alt_filtered[ALT_W-1], alt_filtered}) >>> FILT_SHIFT;
    rate_new = {flt_diff[ALT_W-1:RATE_SHIFT], {RATE_SHIFT{1'b0}}};
    af_new   = alt_filtered + flt_diff[ALT_W-1:0];
    rc_new   = {rate_new[ALT_W-1], rate_new} - {rate_filtered[ALT_W-1], rate_filtered};
    raw_full = {alt_latched[ALT_W-1], alt_latched}
             - {alt_previous[ALT_W-1], alt_previous};
    if (raw_full[ALT_W] != raw_full[ALT_W-1]) begin
      raw_sat = raw_full[ALT_W] ? ALT_MIN : ALT_MAX;
    end else begin
      raw_sat = raw_full[ALT_W-1:0];
    end
  end

  // sample and control timers
  logic signed [TIMER_W:0]   st_dec;
  logic signed [TIMER_W:0]   ct_dec;
  logic signed [TIMER_W-1:0] st_sat;
  logic signed [TIMER_W-1:0] ct_sat;
  logic                      st_fire;
  logic                      ct_fire;

  always_comb begin
    st_dec  = {sample_timer[TIMER_W-1], sample_timer} - tick_ext;
    ct_dec  = {control_timer[TIMER_W-1], control_timer} - tick_ext;
    st_sat  = (st_dec[TIMER_W:TIMER_W-1] == 2'b10) ? TIMER_MIN : st_dec[TIMER_W-1:0];
    ct_sat  = (ct_dec[TIMER_W:TIMER_W-1] == 2'b10) ? TIMER_MIN : ct_dec[TIMER_W-1:0];
    st_fire = st_sat[TIMER_W-1];
    ct_fire = ct_sat[TIMER_W-1];
  end

  // drive and integrator
  logic signed [DRV_W-1:0] drv_full;
  logic                    drv_hi;
  logic                    drv_lo;
  logic signed [DRV_W-1:0] int_sum;
  logic signed [DRV_W-1:0] lim_pos;
  logic signed [DRV_W-1:0] lim_neg;
  logic signed [Q15_W:0]   elev_sum;
  logic signed [Q15_W-1:0] elev_sat;
  logic                    out_free;

  always_comb begin
    drv_full = acc[ACC_W-1:DRV_SHIFT];
    drv_hi   = drv_full > DRV_MAX;
    drv_lo   = drv_full < DRV_MIN;
    int_sum  = drv_full + {{(DRV_W-Q15_W){integrator[Q15_W-1]}}, integrator};
    lim_pos  = {{(DRV_W-LIMIT_W){1'b0}}, cfg.integ_limit};
    lim_neg  = -lim_pos;
    elev_sum = {item.elevator_in[Q15_W-1], item.elevator_in}
             + {last_drive[Q15_W-1], last_drive};
    if (elev_sum[Q15_W] != elev_sum[Q15_W-1]) begin
      elev_sat = elev_sum[Q15_W] ? Q15_MIN : Q15_MAX;
    end else begin
      elev_sat = elev_sum[Q15_W-1:0];
    end
    out_free = !result_valid || result_ready;
  end

  // multiply sequence
  always_comb begin
    mop = '0;
    unique case (state)
      S_SETP: begin
        mop.issue = 1'b1;
        mop.a     = {{(MAC_A_W-Q15_W){item.stick[Q15_W-1]}}, item.stick};
        mop.b     = cfg.stick_scale;
      end
      S_P0: begin
        mop.issue = 1'b1;
        mop.clear = 1'b1;
        mop.a     = {setp[ALT_W-1], setp};
        mop.b     = cfg.prop_gain;
      end
      S_P1: begin
        mop.issue = 1'b1;
        mop.sub   = 1'b1;
        mop.shift = 1'b1;
        mop.a     = {rate_filtered[ALT_W-1], rate_filtered};
        mop.b     = cfg.prop_gain;
      end
      S_P2: begin
        mop.issue = 1'b1;
        mop.shift = 1'b1;
        mop.a     = rate_change;
        mop.b     = cfg.deriv_gain;
      end
      S_P3: begin
        mop.issue = 1'b1;
        mop.a     = {{(MAC_A_W-Q15_W){integrator[Q15_W-1]}}, integrator};
        mop.b     = INTEG_SCALE;
      end
      S_I0: begin
        mop.issue = 1'b1;
        mop.clear = 1'b1;
        mop.a     = {setp[ALT_W-1], setp};
        mop.b     = cfg.integ_gain;
      end
      S_I1: begin
        mop.issue = 1'b1;
        mop.sub   = 1'b1;
        mop.shift = 1'b1;
        mop.a     = {rate_raw[ALT_W-1], rate_raw};
        mop.b     = cfg.integ_gain;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (tick_valid) state_next = S_FILT;
      S_FILT: state_next = S_TIME;
      S_TIME: state_next = ct_fire ? S_SETP : S_FIN;
      S_SETP: state_next = S_SCAP;
      S_SCAP: state_next = S_P0;
      S_P0:   state_next = S_P1;
      S_P1:   state_next = S_P2;
      S_P2:   state_next = S_P3;
      S_P3:   state_next = S_ACCW;
      S_ACCW: state_next = S_DRV;
      S_DRV:  state_next = (drv_hi || drv_lo) ? S_FIN : S_I0;
      S_I0:   state_next = S_I1;
      S_I1:   state_next = S_IW;
      S_IW:   state_next = S_INTG;
      S_INTG: state_next = S_FIN;
      S_FIN:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      delay_timer   <= '0;
      sample_timer  <= '0;
      control_timer <= '0;
      alt_latched   <= '0;
      alt_filtered  <= '0;
      alt_previous  <= '0;
      rate_filtered <= '0;
      rate_raw      <= '0;
      rate_change   <= '0;
      integrator    <= '0;
      last_drive    <= '0;
      primed        <= 1'b0;
      updated       <= 1'b0;
      result_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_FILT && dt_run) begin
        delay_timer <= dt_dec[TIMER_W-1:0];
        if (dt_dec[TIMER_W]) begin
          if (primed) begin
            alt_filtered  <= af_new;
            rate_change   <= rc_new;
            rate_filtered <= rate_new;
            rate_raw      <= raw_sat;
            alt_previous  <= alt_latched;
          end else begin
            primed       <= 1'b1;
            alt_filtered <= alt_latched;
            alt_previous <= alt_latched;
          end
        end
      end
      if (state == S_TIME) begin
        sample_timer  <= st_fire ? st_sat + {2'b00, cfg.sample_period} : st_sat;
        control_timer <= ct_fire ? ct_sat + {2'b00, cfg.control_period} : ct_sat;
        updated       <= ct_fire;
        if (st_fire) begin
          delay_timer <= {2'b00, cfg.sample_delay};
          alt_latched <= item.altitude_counts;
        end
      end
      if (state == S_DRV) begin
        priority if (drv_hi) begin
          last_drive <= DRV_MAX[Q15_W-1:0];
        end else if (drv_lo) begin
          last_drive <= DRV_MIN[Q15_W-1:0];
        end else begin
          last_drive <= drv_full[Q15_W-1:0];
        end
      end
      if (state == S_INTG) begin
        priority if (int_sum > lim_pos) begin
          integrator <= lim_pos[Q15_W-1:0];
        end else if (int_sum < lim_neg) begin
          integrator <= lim_neg[Q15_W-1:0];
        end else begin
          integrator <= int_sum[Q15_W-1:0];
        end
      end
      if (state == S_FIN && out_free) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tick_valid && tick_ready) begin
      item <= tick_item;
    end
    if (state == S_SCAP) begin
      setp <= prod[SETP_SHIFT+ALT_W-1:SETP_SHIFT];
    end
    if (state == S_FIN && out_free) begin
      result_item.elevator_out <= elev_sat;
      result_item.drive        <= last_drive;
      result_item.updated      <= updated;
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (tick_valid && tick_ready) |=> !tick_ready)
    else $error("accepted an item while one is in flight");

  a_mac_drained: assert property (@(posedge clk) disable iff (rst)
    (state == S_DRV || state == S_INTG) |-> !mac_busy)
    else $error("accumulator read before the last product was added");

  a_drive_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ($signed(result_item.drive) <= $signed(DRV_MAX[Q15_W-1:0])
                   && $signed(result_item.drive) >= $signed(DRV_MIN[Q15_W-1:0])))
    else $error("drive outside half scale");

  a_result_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state == S_FIN))
    else $error("result raised outside the final step");

endmodule

// ===== tb/climb_rate_pi_controller_tb.sv =====
// Testbench for climb_rate_pi_controller: directed and random ticks with random idling
// on both channels, checked against a bit-exact predictor of filter, timers and drive.
// Depends on crpi_pkg and the climb_rate_pi_controller RTL.
module climb_rate_pi_controller_tb;
  import crpi_pkg::*;

  localparam longint TMR_FLOOR = -(longint'(1) <<< (TIMER_W - 1));
  localparam longint ALT_HI    = (longint'(1) <<< (ALT_W - 1)) - 1;
  localparam longint ALT_LO    = -ALT_HI - 1;
  localparam longint Q15_HI    = (longint'(1) <<< (Q15_W - 1)) - 1;
  localparam longint Q15_LO    = -Q15_HI - 1;
  localparam int     GAIN_MAX  = 8388607;
  localparam int     GAIN_MIN  = -8388608;
  localparam int     PER_MAX   = 1048575;
  localparam int     LIM_MAX   = 32767;

  logic         clk;
  logic         rst;
  logic         tick_valid;
  logic         tick_ready;
  tick_item_t   tick_item;
  logic         result_valid;
  logic         result_ready;
  result_item_t result_item;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  climb_rate_pi_controller DUT (
    .clk          (clk),
    .rst          (rst),
    .tick_valid   (tick_valid),
    .tick_ready   (tick_ready),
    .tick_item    (tick_item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_item  (result_item),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // predictor registers and state
  longint prop_k, deriv_k, integ_k, stick_k, ctrl_per, smpl_per, smpl_dly, int_lim;
  longint alt_hold, alt_filt, alt_prev, climb_filt, climb_raw, climb_delta;
  longint integ_acc, drive_hold, smpl_tmr, dly_tmr, ctrl_tmr;
  bit     seeded;

  result_item_t pending_results[$];
  result_item_t want;
  int     errors;
  bit     quiet;
  int     hold_req;
  int     hold_left;
  int     ready_wait;
  int     tick_lo, tick_hi;
  int     alt_walk;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint sat(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic void reset_model();
    prop_k = 0; deriv_k = 0; integ_k = 0; stick_k = 0;
    ctrl_per = longint'(CTRL_PERIOD_RST);
    smpl_per = longint'(SMPL_PERIOD_RST);
    smpl_dly = longint'(SMPL_DELAY_RST);
    int_lim  = longint'(INTEG_LIMIT_RST);
    alt_hold = 0; alt_filt = 0; alt_prev = 0;
    climb_filt = 0; climb_raw = 0; climb_delta = 0;
    integ_acc = 0; drive_hold = 0;
    smpl_tmr = 0; dly_tmr = 0; ctrl_tmr = 0;
    seeded = 1'b0;
  endfunction

  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] d);
    case (idx)
      REG_PROP_GAIN:      prop_k   = longint'(signed'(d));
      REG_DERIV_GAIN:     deriv_k  = longint'(signed'(d));
      REG_INTEG_GAIN:     integ_k  = longint'(signed'(d));
      REG_STICK_SCALE:    stick_k  = longint'(signed'(d));
      REG_CONTROL_PERIOD: ctrl_per = longint'(d[PERIOD_W-1:0]);
      REG_SAMPLE_PERIOD:  smpl_per = longint'(d[PERIOD_W-1:0]);
      REG_SAMPLE_DELAY:   smpl_dly = longint'(d[PERIOD_W-1:0]);
      REG_INTEG_LIMIT:    int_lim  = longint'(d[LIMIT_W-1:0]);
    endcase
  endfunction

  function automatic result_item_t predict_tick(input tick_item_t it);
    longint dt, alt, stk, elev, drv, diff, rnew, setp, acc, inc, outv;
    result_item_t r;
    dt   = longint'(it.tick_us);
    alt  = longint'(signed'(it.altitude_counts));
    stk  = longint'(signed'(it.stick));
    elev = longint'(signed'(it.elevator_in));
    r.updated = 1'b0;

    if (dly_tmr > 0) begin
      dly_tmr = dly_tmr - dt;
      if (dly_tmr < 0) begin
        if (seeded) begin
          diff = (alt_hold - alt_filt) >>> FILT_SHIFT;
          rnew = (diff >>> RATE_SHIFT) * (longint'(1) <<< RATE_SHIFT);
          alt_filt    = alt_filt + diff;
          climb_delta = rnew - climb_filt;
          climb_filt  = rnew;
          climb_raw   = sat(alt_hold - alt_prev, ALT_LO, ALT_HI);
          alt_prev    = alt_hold;
        end else begin
          seeded   = 1'b1;
          alt_filt = alt_hold;
          alt_prev = alt_hold;
        end
      end
    end

    smpl_tmr = sat(smpl_tmr - dt, TMR_FLOOR, 64'sh7fff_ffff_ffff_ffff);
    if (smpl_tmr < 0) begin
      smpl_tmr = smpl_tmr + smpl_per;
      dly_tmr  = smpl_dly;
      alt_hold = alt;
    end

    ctrl_tmr = sat(ctrl_tmr - dt, TMR_FLOOR, 64'sh7fff_ffff_ffff_ffff);
    if (ctrl_tmr < 0) begin
      ctrl_tmr  = ctrl_tmr + ctrl_per;
      r.updated = 1'b1;
      setp = (stk * stick_k) >>> SETP_SHIFT;
      acc  = (setp - climb_filt * 256) * prop_k + climb_delta * deriv_k * 256
           + integ_acc * 512;
      drv  = acc >>> DRV_SHIFT;
      if (drv > HALF_Q15) begin
        drv = HALF_Q15;
      end else if (drv < -HALF_Q15) begin
        drv = -HALF_Q15;
      end else begin
        inc = ((setp - climb_raw * 256) * integ_k) >>> DRV_SHIFT;
        integ_acc = sat(integ_acc + inc, -int_lim, int_lim);
      end
      drive_hold = drv;
    end else begin
      drv = drive_hold;
    end

    outv = sat(elev + drv, Q15_LO, Q15_HI);
    r.elevator_out = outv[Q15_W-1:0];
    r.drive        = drv[Q15_W-1:0];
    return r;
  endfunction

  function automatic int rand_signed(input int w);
    int v;
    v = $urandom;
    v = v & ((1 << w) - 1);
    if ((v >> (w - 1)) & 1)
      v = v - (1 << w);
    return v;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60)
      return 0;
    if (r < 95)
      return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic tick_item_t mk(input int t, input int a, input int s, input int e);
    tick_item_t it;
    it.tick_us         = t[TICK_W-1:0];
    it.altitude_counts = a[ALT_W-1:0];
    it.stick           = s[Q15_W-1:0];
    it.elevator_in     = e[Q15_W-1:0];
    return it;
  endfunction

  function automatic tick_item_t random_item();
    int r, t;
    r = $urandom_range(0, 99);
    if (r < 5)
      t = 0;
    else if (r < 10)
      t = 65535;
    else
      t = $urandom_range(tick_lo, tick_hi);
    r = $urandom_range(0, 99);
    if (r < 85)
      alt_walk = int'(sat(alt_walk + rand_signed($urandom_range(1, 12)), ALT_LO, ALT_HI));
    else if (r < 95)
      alt_walk = rand_signed(ALT_W);
    else
      alt_walk = r[0] ? int'(ALT_HI) : int'(ALT_LO);
    return mk(t, alt_walk, rand_signed(Q15_W), rand_signed(Q15_W));
  endfunction

  function automatic int pick_gain();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8)
      return GAIN_MAX;
    if (r < 16)
      return GAIN_MIN;
    if (r < 20)
      return 0;
    return rand_signed($urandom_range(1, 24));
  endfunction

  task automatic send_tick(input tick_item_t it);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      tick_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    tick_item  = it;
    tick_valid = 1'b1;
    do @(posedge clk); while (!tick_ready);
    pending_results.push_back(predict_tick(it));
  endtask

  // only written with the block idle: no item offered, no result outstanding
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    @(negedge clk);
    tick_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    @(negedge clk);
    cfg_index = idx;
    cfg_data  = val[CFG_DATA_W-1:0];
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, cfg_data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_periods(input int ctrl, input int smpl, input int dly);
    write_reg(REG_CONTROL_PERIOD, ctrl);
    write_reg(REG_SAMPLE_PERIOD, smpl);
    write_reg(REG_SAMPLE_DELAY, dly);
  endtask

  task automatic set_gains(input int kp, input int kd, input int ki, input int ks);
    write_reg(REG_PROP_GAIN, kp);
    write_reg(REG_DERIV_GAIN, kd);
    write_reg(REG_INTEG_GAIN, ki);
    write_reg(REG_STICK_SCALE, ks);
  endtask

  // reset settings, all gains zero: elevator passes through untouched
  task automatic test_passthrough();
    send_tick(mk(0, 0, 0, 1234));
    send_tick(mk(65535, int'(ALT_HI), 32767, 32767));
    send_tick(mk(65535, int'(ALT_LO), -32768, -32768));
    send_tick(mk(0, -1, -1, -1));
  endtask

  // full-scale gains, altitude swinging rail to rail: raw rate saturates,
  // drive clamps both ways, elevator sum saturates
  task automatic test_extremes();
    int k;
    set_gains(GAIN_MAX, GAIN_MIN, GAIN_MAX, GAIN_MAX);
    write_reg(REG_INTEG_LIMIT, LIM_MAX);
    set_periods(100, 300, 150);
    for (k = 0; k < 10; k++)
      send_tick(mk(100, k[0] ? int'(ALT_LO) : int'(ALT_HI),
                   k[1] ? -32768 : 32767, k[0] ? -32768 : 32767));
  endtask

  // only the integrator drives: it runs into its limit in both directions
  task automatic test_integ_limit();
    int k;
    set_gains(0, 0, GAIN_MAX, GAIN_MAX);
    write_reg(REG_INTEG_LIMIT, 100);
    for (k = 0; k < 6; k++)
      send_tick(mk(100, 5000 * k, (k < 3) ? 32767 : -32768, 0));
  endtask

  // zero periods and zero dead time, with zero-length ticks in between
  task automatic test_zero_periods();
    set_gains(3000, -2000, 1000, 40000);
    set_periods(0, 0, 0);
    send_tick(mk(0, 100, 1000, 0));
    send_tick(mk(1, 200, 1000, 0));
    send_tick(mk(0, 300, -1000, 0));
    send_tick(mk(500, 400, -1000, 0));
    send_tick(mk(0, 500, 2000, 0));
  endtask

  // long ticks against tiny periods drive both timers onto their floor,
  // then a long period has to catch up over several ticks
  task automatic test_timer_floor();
    int k;
    set_periods(1, 1, 5000);
    for (k = 0; k < 36; k++)
      send_tick(mk(65535, rand_signed(ALT_W), rand_signed(Q15_W), rand_signed(Q15_W)));
    set_periods(PER_MAX, PER_MAX, 2000);
    for (k = 0; k < 10; k++)
      send_tick(mk(1000, rand_signed(ALT_W), rand_signed(Q15_W), rand_signed(Q15_W)));
  endtask

  task automatic test_random_phases();
    int ph, k, c, sp;
    for (ph = 0; ph < 12; ph++) begin
      if (ph == 0)
        set_gains(GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX);
      else if (ph == 1)
        set_gains(GAIN_MIN, GAIN_MIN, GAIN_MIN, GAIN_MIN);
      else
        set_gains(pick_gain(), pick_gain(), pick_gain(), pick_gain());
      if (ph == 1)
        write_reg(REG_INTEG_LIMIT, 0);
      else if (ph == 2)
        write_reg(REG_INTEG_LIMIT, LIM_MAX);
      else
        write_reg(REG_INTEG_LIMIT, $urandom_range(0, LIM_MAX));
      c = $urandom_range(0, 99);
      if (c < 50) begin
        sp = $urandom_range(2, 1500);
        set_periods($urandom_range(1, 400), sp, $urandom_range(1, sp - 1));
        tick_lo = 0; tick_hi = 300;
      end else if (c < 75) begin
        sp = $urandom_range(100000, 200000);
        set_periods($urandom_range(10000, 30000), sp, sp / 2);
        tick_lo = 1000; tick_hi = 20000;
      end else if (c < 87) begin
        set_periods(PER_MAX, PER_MAX, $urandom_range(1, PER_MAX - 1));
        tick_lo = 30000; tick_hi = 65535;
      end else begin
        set_periods($urandom_range(1, PER_MAX), $urandom_range(1, PER_MAX),
                    $urandom_range(0, PER_MAX));
        tick_lo = 0; tick_hi = 65535;
      end
      quiet = ($urandom_range(0, 3) == 0);
      for (k = 0; k < 72; k++)
        send_tick(random_item());
    end
    quiet = 1'b0;
  endtask

  // receiver holds off while ticks keep coming, so the block must stall its input
  task automatic test_backpressure();
    int k;
    quiet    = 1'b1;
    hold_req = 300;
    for (k = 0; k < 40; k++)
      send_tick(random_item());
    quiet = 1'b0;
  endtask

  always @(negedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      result_ready = 1'b0;
    end else if (ready_wait > 0) begin
      ready_wait--;
      result_ready = 1'b0;
    end else begin
      result_ready = 1'b1;
      ready_wait   = pick_gap();
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 100)
          $display("%0t: unexpected result, actual elevator_out %0d drive %0d updated %0d",
                   $time, $signed(result_item.elevator_out), $signed(result_item.drive),
                   result_item.updated);
      end else begin
        want = pending_results.pop_front();
        if (result_item.elevator_out !== want.elevator_out ||
            result_item.drive !== want.drive || result_item.updated !== want.updated) begin
          errors++;
          if (errors <= 100)
            $display("%0t: mismatch, expected elevator_out %0d drive %0d updated %0d, actual %0d %0d %0d",
                     $time, $signed(want.elevator_out), $signed(want.drive), want.updated,
                     $signed(result_item.elevator_out), $signed(result_item.drive),
                     result_item.updated);
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    clk          = 1'b0;
    rst          = 1'b1;
    tick_valid   = 1'b0;
    tick_item    = '0;
    result_ready = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = REG_PROP_GAIN;
    cfg_data     = '0;
    errors       = 0;
    quiet        = 1'b0;
    hold_req     = 0;
    hold_left    = 0;
    ready_wait   = 0;
    tick_lo      = 0;
    tick_hi      = 300;
    alt_walk     = 0;
    reset_model();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_passthrough();
    test_extremes();
    test_integ_limit();
    test_zero_periods();
    test_timer_floor();
    test_random_phases();
    test_backpressure();

    @(negedge clk);
    tick_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
